/* hdl/rcw_pkg.sv */
package rcw_pkg;

  // panel geometry
  localparam int unsigned MAX_SIDE = 1024;
  localparam int unsigned SIDE_W   = $clog2(MAX_SIDE + 1);
  localparam int unsigned COORD_W  = $clog2(MAX_SIDE);
  localparam int unsigned PROD_W   = 2 * SIDE_W;

  // clip arithmetic width, wide enough for any 16-bit corner plus size
  localparam int unsigned CALC_W = 18;

  // field widths
  localparam int unsigned FIELD_W  = 16;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned REPEAT_W = 21;
  localparam logic [REPEAT_W-1:0] REPEAT_MAX = '1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] CFG_PANEL_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] CFG_WIDE_BUS     = 2'd2;

  // reset values
  localparam logic [CFG_W-1:0] PANEL_WIDTH_RST  = 11'd320;
  localparam logic [CFG_W-1:0] PANEL_HEIGHT_RST = 11'd480;

  // panel command codes
  localparam logic [FIELD_W-1:0] CMD_COLUMN = 16'h002A;
  localparam logic [FIELD_W-1:0] CMD_PAGE   = 16'h002B;
  localparam logic [FIELD_W-1:0] CMD_WRITE  = 16'h002C;
  localparam logic [FIELD_W-1:0] BYTE_MASK  = 16'h00FF;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [SIDE_W-1:0]  side_t;

  // one clipped rectangle
  typedef struct packed {
    coord_t             x0;
    coord_t             x1;
    coord_t             y0;
    coord_t             y1;
    side_t              w;
    side_t              h;
    logic [FIELD_W-1:0] color;
  } rect_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  // output slots of one rectangle's command stream
  typedef enum logic [3:0] {
    SL_CMD_COL,
    SL_X0_HI,
    SL_X0_LO,
    SL_X1_HI,
    SL_X1_LO,
    SL_CMD_PAGE,
    SL_Y0_HI,
    SL_Y0_LO,
    SL_Y1_HI,
    SL_Y1_LO,
    SL_CMD_WRITE,
    SL_FILL
  } slot_e;

endpackage

/* hdl/rcw_clip.sv */
module rcw_clip import rcw_pkg::*; (
  input  logic                      start_i,
  input  q_status_t                 status_i,
  input  logic signed [FIELD_W-1:0] rect_x_i,
  input  logic signed [FIELD_W-1:0] rect_y_i,
  input  logic signed [FIELD_W-1:0] rect_w_i,
  input  logic signed [FIELD_W-1:0] rect_h_i,
  input  logic [FIELD_W-1:0]        fill_color_i,
  input  logic [CFG_W-1:0]          panel_width_i,
  input  logic [CFG_W-1:0]          panel_height_i,
  output logic                      push_o,
  output rect_t                     entry_o
);

  logic [CALC_W-1:0]        pw_raw, ph_raw;
  logic signed [CALC_W-1:0] pw_s, ph_s;
  logic signed [CALC_W-1:0] x_s, y_s, w_s, h_s;
  logic signed [CALC_W-1:0] x_lo, y_lo, x_end, y_end, x_endc, y_endc;
  logic signed [CALC_W-1:0] w_c, h_c, x_last, y_last;
  logic                     nonempty;

  // panel size limited to the largest supported side
  assign pw_raw = CALC_W'(panel_width_i);
  assign ph_raw = CALC_W'(panel_height_i);
  assign pw_s   = (pw_raw > CALC_W'(MAX_SIDE)) ? CALC_W'(MAX_SIDE) : pw_raw;
  assign ph_s   = (ph_raw > CALC_W'(MAX_SIDE)) ? CALC_W'(MAX_SIDE) : ph_raw;

  // sign-extend the request
  assign x_s = {{(CALC_W-FIELD_W){rect_x_i[FIELD_W-1]}}, rect_x_i};
  assign y_s = {{(CALC_W-FIELD_W){rect_y_i[FIELD_W-1]}}, rect_y_i};
  assign w_s = {{(CALC_W-FIELD_W){rect_w_i[FIELD_W-1]}}, rect_w_i};
  assign h_s = {{(CALC_W-FIELD_W){rect_h_i[FIELD_W-1]}}, rect_h_i};

  // left/top edge clamped at zero, exclusive far edge clamped at panel size
  assign x_lo   = x_s[CALC_W-1] ? '0 : x_s;
  assign y_lo   = y_s[CALC_W-1] ? '0 : y_s;
  assign x_end  = x_s + w_s;
  assign y_end  = y_s + h_s;
  assign x_endc = (x_end > pw_s) ? pw_s : x_end;
  assign y_endc = (y_end > ph_s) ? ph_s : y_end;

  // clipped size and inclusive far edge
  assign w_c    = x_endc - x_lo;
  assign h_c    = y_endc - y_lo;
  assign x_last = x_endc - CALC_W'(1);
  assign y_last = y_endc - CALC_W'(1);

  assign nonempty = !w_c[CALC_W-1] && (w_c != '0) && !h_c[CALC_W-1] && (h_c != '0);

  // empty rectangles are dropped here
  assign push_o = start_i && !status_i.full && nonempty;

  assign entry_o.x0    = x_lo[COORD_W-1:0];
  assign entry_o.x1    = x_last[COORD_W-1:0];
  assign entry_o.y0    = y_lo[COORD_W-1:0];
  assign entry_o.y1    = y_last[COORD_W-1:0];
  assign entry_o.w     = w_c[SIDE_W-1:0];
  assign entry_o.h     = h_c[SIDE_W-1:0];
  assign entry_o.color = fill_color_i;

endmodule

/* hdl/rcw_queue.sv */
module rcw_queue import rcw_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  rect_t     entry_i,
  input  logic      pop_i,
  output q_status_t status_o,
  output rect_t     head_o
);

  rect_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  assign head_o         = mem_q[rd_ptr_q];
  assign status_o.empty = (count_q == '0);
  assign status_o.full  = (count_q == QCNT_W'(QUEUE_DEPTH));

`ifndef SYNTHESIS
  // front never writes a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("rect request pushed into full queue");

  // back never reads an empty queue
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("rect request popped from empty queue");
`endif

endmodule

/* hdl/rcw_seq.sv */
module rcw_seq import rcw_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  q_status_t           status_i,
  input  rect_t               head_i,
  input  logic                wide_bus_mode_i,
  output logic                pop_o,
  output logic                result_strobe_o,
  output logic                is_command_o,
  output logic [FIELD_W-1:0]  bus_value_o,
  output logic                two_bytes_o,
  output logic [REPEAT_W-1:0] repeat_count_o,
  output logic                last_item_o
);

  localparam int unsigned EXT_W = PROD_W + REPEAT_W;

  slot_e               slot_q, slot_d;
  logic                active_q, active_d;
  rect_t               cur_q;
  logic [PROD_W-1:0]   prod_q;
  logic [EXT_W-1:0]    prod_ext;
  logic [REPEAT_W-1:0] count_sat;
  logic                take;

  logic                strobe_q;
  logic                is_cmd_q, is_cmd_d;
  logic [FIELD_W-1:0]  value_q, value_d;
  logic                two_q, two_d;
  logic [REPEAT_W-1:0] rep_q, rep_d;
  logic                last_q, last_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q   <= SL_CMD_COL;
      active_q <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      slot_q   <= slot_d;
      active_q <= active_d;
      strobe_q <= active_q;
    end
  end

  // pixel count, saturated to the repeat field
  assign prod_ext  = EXT_W'(prod_q);
  assign count_sat = (prod_ext > EXT_W'(REPEAT_MAX)) ? REPEAT_MAX : prod_ext[REPEAT_W-1:0];

  // next slot and item decode
  always_comb begin
    logic [FIELD_W-1:0] word;
    logic               done;
    logic               hi;

    done     = active_q && (slot_q == SL_FILL);
    take     = (!active_q || done) && !status_i.empty;
    active_d = take ? 1'b1 : (done ? 1'b0 : active_q);
    slot_d   = slot_q;

    if (take) begin
      slot_d = SL_CMD_COL;
    end else if (active_q) begin
      unique case (slot_q)
        SL_CMD_COL:   slot_d = wide_bus_mode_i ? SL_X0_HI : SL_X0_LO;
        SL_X0_HI:     slot_d = SL_X0_LO;
        SL_X0_LO:     slot_d = wide_bus_mode_i ? SL_X1_HI : SL_X1_LO;
        SL_X1_HI:     slot_d = SL_X1_LO;
        SL_X1_LO:     slot_d = SL_CMD_PAGE;
        SL_CMD_PAGE:  slot_d = wide_bus_mode_i ? SL_Y0_HI : SL_Y0_LO;
        SL_Y0_HI:     slot_d = SL_Y0_LO;
        SL_Y0_LO:     slot_d = wide_bus_mode_i ? SL_Y1_HI : SL_Y1_LO;
        SL_Y1_HI:     slot_d = SL_Y1_LO;
        SL_Y1_LO:     slot_d = SL_CMD_WRITE;
        SL_CMD_WRITE: slot_d = SL_FILL;
        SL_FILL:      slot_d = SL_CMD_COL;
        default:      slot_d = SL_CMD_COL;
      endcase
    end

    // defaults describe a coordinate data item
    word     = '0;
    hi       = 1'b0;
    is_cmd_d = 1'b0;
    two_d    = 1'b1;
    rep_d    = REPEAT_W'(1);
    last_d   = 1'b0;
    value_d  = '0;

    unique case (slot_q)
      SL_CMD_COL: begin
        is_cmd_d = 1'b1;
        two_d    = wide_bus_mode_i;
        value_d  = CMD_COLUMN;
      end
      SL_CMD_PAGE: begin
        is_cmd_d = 1'b1;
        two_d    = wide_bus_mode_i;
        value_d  = CMD_PAGE;
      end
      SL_CMD_WRITE: begin
        is_cmd_d = 1'b1;
        two_d    = wide_bus_mode_i;
        value_d  = CMD_WRITE;
      end
      SL_FILL: begin
        value_d = cur_q.color;
        rep_d   = count_sat;
        last_d  = 1'b1;
      end
      SL_X0_HI: begin
        word = FIELD_W'(cur_q.x0);
        hi   = 1'b1;
      end
      SL_X0_LO: word = FIELD_W'(cur_q.x0);
      SL_X1_HI: begin
        word = FIELD_W'(cur_q.x1);
        hi   = 1'b1;
      end
      SL_X1_LO: word = FIELD_W'(cur_q.x1);
      SL_Y0_HI: begin
        word = FIELD_W'(cur_q.y0);
        hi   = 1'b1;
      end
      SL_Y0_LO: word = FIELD_W'(cur_q.y0);
      SL_Y1_HI: begin
        word = FIELD_W'(cur_q.y1);
        hi   = 1'b1;
      end
      SL_Y1_LO: word = FIELD_W'(cur_q.y1);
      default: word = '0;
    endcase

    // coordinate split into bytes on the wide bus, whole word otherwise
    if (!is_cmd_d && !last_d) begin
      if (hi) begin
        value_d = (word >> 8) & BYTE_MASK;
      end else begin
        value_d = wide_bus_mode_i ? (word & BYTE_MASK) : word;
      end
    end
  end

  assign pop_o = take;

  // current rectangle and its pixel product
  always_ff @(posedge clk_i) begin
    if (take) begin
      cur_q <= head_i;
    end
    prod_q   <= cur_q.w * cur_q.h;
    is_cmd_q <= is_cmd_d;
    value_q  <= value_d;
    two_q    <= two_d;
    rep_q    <= rep_d;
    last_q   <= last_d;
  end

  assign result_strobe_o = strobe_q;
  assign is_command_o    = is_cmd_q;
  assign bus_value_o     = value_q;
  assign two_bytes_o     = two_q;
  assign repeat_count_o  = rep_q;
  assign last_item_o     = last_q;

`ifndef SYNTHESIS
  // fill item always carries at least one pixel
  a_fill_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_item_o) |-> (repeat_count_o != '0))
    else $error("fill item with zero pixel count");

  // every other item is sent once
  a_single_repeat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_item_o) |-> (repeat_count_o == REPEAT_W'(1)))
    else $error("non-fill item with repeat count other than one");

  // a run of results opens with the column-address command
  a_burst_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(result_strobe_o) |-> (is_command_o && (bus_value_o == CMD_COLUMN)))
    else $error("result run does not start with column command");
`endif

endmodule

/* hdl/rect_clip_window_command_gen.sv */
// Clips a signed rectangle to the panel and emits the window-fill command
// stream: column command and range, page command and range, memory-write
// command, then one fill item with the colour and pixel count. A rectangle
// is taken when start is high and busy is low; one clipped away entirely
// gives no results. Results leave one per cycle, each on the ports for one
// cycle with result_strobe_o high, and the receiver cannot stall them. The
// back-end sequencer emits twelve results per rectangle on the wide bus
// and eight on the narrow bus. The front clips in the cycle of acceptance and
// places the rectangle in a two-entry queue, so busy rises only when both
// entries wait; into an empty block a rectangle passes the queue and the
// slot register before its first result is registered. Configuration writes
// are always ready and must only be made while the block is idle.
module rect_clip_window_command_gen import rcw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic signed [FIELD_W-1:0] rect_x_i,
  input  logic signed [FIELD_W-1:0] rect_y_i,
  input  logic signed [FIELD_W-1:0] rect_w_i,
  input  logic signed [FIELD_W-1:0] rect_h_i,
  input  logic [FIELD_W-1:0]        fill_color_i,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [REG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  output logic                      result_strobe_o,
  output logic                      is_command_o,
  output logic [FIELD_W-1:0]        bus_value_o,
  output logic                      two_bytes_o,
  output logic [REPEAT_W-1:0]       repeat_count_o,
  output logic                      last_item_o
);

  logic [CFG_W-1:0] panel_width_q, panel_height_q;
  logic             wide_bus_q;
  q_status_t        q_status;
  rect_t            push_entry, head_entry;
  logic             push, pop;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q  <= PANEL_WIDTH_RST;
      panel_height_q <= PANEL_HEIGHT_RST;
      wide_bus_q     <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_PANEL_WIDTH) begin
        panel_width_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_PANEL_HEIGHT) begin
        panel_height_q <= cfg_data_i;
      end
      if (cfg_index_i == CFG_WIDE_BUS) begin
        wide_bus_q <= cfg_data_i[0];
      end
    end
  end

  assign busy = q_status.full;

  // front: accept and clip
  rcw_clip u_clip (
    .start_i        (start),
    .status_i       (q_status),
    .rect_x_i       (rect_x_i),
    .rect_y_i       (rect_y_i),
    .rect_w_i       (rect_w_i),
    .rect_h_i       (rect_h_i),
    .fill_color_i   (fill_color_i),
    .panel_width_i  (panel_width_q),
    .panel_height_i (panel_height_q),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // queue of clipped rectangles
  rcw_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .status_o (q_status),
    .head_o   (head_entry)
  );

  // back: command sequencer
  rcw_seq u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .status_i        (q_status),
    .head_i          (head_entry),
    .wide_bus_mode_i (wide_bus_q),
    .pop_o           (pop),
    .result_strobe_o (result_strobe_o),
    .is_command_o    (is_command_o),
    .bus_value_o     (bus_value_o),
    .two_bytes_o     (two_bytes_o),
    .repeat_count_o  (repeat_count_o),
    .last_item_o     (last_item_o)
  );

endmodule

/* tb/sv/rcw_checker.sv */
`timescale 1ns / 100ps

// watches the rectangle, configuration and result channels of the window
// command generator, predicts each command stream and compares it
module rcw_checker import rcw_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic signed [FIELD_W-1:0] rect_x_i,
  input  logic signed [FIELD_W-1:0] rect_y_i,
  input  logic signed [FIELD_W-1:0] rect_w_i,
  input  logic signed [FIELD_W-1:0] rect_h_i,
  input  logic [FIELD_W-1:0]        fill_color_i,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [REG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_W-1:0]          cfg_data_i,
  input  logic                      result_strobe_i,
  input  logic                      is_command_i,
  input  logic [FIELD_W-1:0]        bus_value_i,
  input  logic                      two_bytes_i,
  input  logic [REPEAT_W-1:0]       repeat_count_i,
  input  logic                      last_item_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  // one item of the panel command stream
  typedef struct packed {
    logic                is_cmd;
    logic [FIELD_W-1:0]  value;
    logic                two;
    logic [REPEAT_W-1:0] rep;
    logic                last;
  } bus_item_t;

  bus_item_t        stream_q[$];
  logic [CFG_W-1:0] panel_w_q;
  logic [CFG_W-1:0] panel_h_q;
  logic             wide_q;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic void push_item(input logic is_cmd, input logic [FIELD_W-1:0] value,
                                    input logic two, input logic [REPEAT_W-1:0] rep,
                                    input logic last);
    bus_item_t it;
    it.is_cmd = is_cmd;
    it.value  = value;
    it.two    = two;
    it.rep    = rep;
    it.last   = last;
    stream_q.push_back(it);
  endfunction

  // address command followed by its start and end coordinate
  function automatic void push_range(input logic [FIELD_W-1:0] cmd, input int a, input int b);
    logic [FIELD_W-1:0] av;
    logic [FIELD_W-1:0] bv;
    av = a[FIELD_W-1:0];
    bv = b[FIELD_W-1:0];
    if (wide_q) begin
      push_item(1'b1, cmd, 1'b1, REPEAT_W'(1), 1'b0);
      push_item(1'b0, (av >> 8) & BYTE_MASK, 1'b1, REPEAT_W'(1), 1'b0);
      push_item(1'b0, av & BYTE_MASK, 1'b1, REPEAT_W'(1), 1'b0);
      push_item(1'b0, (bv >> 8) & BYTE_MASK, 1'b1, REPEAT_W'(1), 1'b0);
      push_item(1'b0, bv & BYTE_MASK, 1'b1, REPEAT_W'(1), 1'b0);
    end else begin
      push_item(1'b1, cmd, 1'b0, REPEAT_W'(1), 1'b0);
      push_item(1'b0, av, 1'b1, REPEAT_W'(1), 1'b0);
      push_item(1'b0, bv, 1'b1, REPEAT_W'(1), 1'b0);
    end
  endfunction

  // clip to the panel and queue the window fill stream, if any pixel is left
  function automatic void predict_window(input logic signed [FIELD_W-1:0] rx,
                                         input logic signed [FIELD_W-1:0] ry,
                                         input logic signed [FIELD_W-1:0] rw,
                                         input logic signed [FIELD_W-1:0] rh,
                                         input logic [FIELD_W-1:0] colour);
    int                  cx;
    int                  cy;
    int                  cw;
    int                  ch;
    int                  pw;
    int                  ph;
    longint              pixels;
    logic [REPEAT_W-1:0] rep;
    cx = int'(rx);
    cy = int'(ry);
    cw = int'(rw);
    ch = int'(rh);
    pw = (panel_w_q > MAX_SIDE) ? int'(MAX_SIDE) : int'(panel_w_q);
    ph = (panel_h_q > MAX_SIDE) ? int'(MAX_SIDE) : int'(panel_h_q);
    if (cx < 0) begin
      cw = cw + cx;
      cx = 0;
    end
    if (cy < 0) begin
      ch = ch + cy;
      cy = 0;
    end
    if (cx + cw > pw) cw = pw - cx;
    if (cy + ch > ph) ch = ph - cy;
    if (cw < 1 || ch < 1) return;
    pixels = longint'(cw) * longint'(ch);
    if (pixels > longint'(REPEAT_MAX)) rep = REPEAT_MAX;
    else rep = pixels[REPEAT_W-1:0];
    push_range(CMD_COLUMN, cx, cx + cw - 1);
    push_range(CMD_PAGE, cy, cy + ch - 1);
    push_item(1'b1, CMD_WRITE, wide_q, REPEAT_W'(1), 1'b0);
    push_item(1'b0, colour, 1'b1, rep, 1'b1);
  endfunction

  // sample all channels at the rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    bus_item_t want;
    if (!rst_ni) begin
      panel_w_q = PANEL_WIDTH_RST;
      panel_h_q = PANEL_HEIGHT_RST;
      wide_q    = 1'b1;
    end else begin
      // compare each result with the oldest expected item
      if (result_strobe_i) begin
        if (stream_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value %0h", bus_value_i));
        end else begin
          want = stream_q.pop_front();
          if (is_command_i !== want.is_cmd)
            report_mismatch($sformatf("is_command %0b, want %0b", is_command_i, want.is_cmd));
          if (bus_value_i !== want.value)
            report_mismatch($sformatf("bus_value %0h, want %0h", bus_value_i, want.value));
          if (two_bytes_i !== want.two)
            report_mismatch($sformatf("two_bytes %0b, want %0b", two_bytes_i, want.two));
          if (repeat_count_i !== want.rep)
            report_mismatch($sformatf("repeat_count %0d, want %0d", repeat_count_i, want.rep));
          if (last_item_i !== want.last)
            report_mismatch($sformatf("last_item %0b, want %0b", last_item_i, want.last));
        end
      end
      // register write request
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_PANEL_WIDTH:  panel_w_q = cfg_data_i;
          CFG_PANEL_HEIGHT: panel_h_q = cfg_data_i;
          CFG_WIDE_BUS:     wide_q    = cfg_data_i[0];
          default: ;
        endcase
      end
      // rectangle request
      if (start_i && !busy_i)
        predict_window(rect_x_i, rect_y_i, rect_w_i, rect_h_i, fill_color_i);
    end
    pending_o = stream_q.size();
  end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
  import rcw_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [REG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      start = 1'b0;
  logic                      busy;
  logic signed [FIELD_W-1:0] rect_x = '0;
  logic signed [FIELD_W-1:0] rect_y = '0;
  logic signed [FIELD_W-1:0] rect_w = '0;
  logic signed [FIELD_W-1:0] rect_h = '0;
  logic [FIELD_W-1:0]        fill_color = '0;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [REG_IDX_W-1:0]      cfg_index = '0;
  logic [CFG_W-1:0]          cfg_data = '0;
  logic                      result_strobe;
  logic                      is_command;
  logic [FIELD_W-1:0]        bus_value;
  logic                      two_bytes;
  logic [REPEAT_W-1:0]       repeat_count;
  logic                      last_item;
  int                        fail_count;
  int                        pending;
  int                        quiet_cycles = 0;
  int                        cur_pw = 320;
  int                        cur_ph = 480;
  bit                        idle_on = 1'b0;

  rect_clip_window_command_gen u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .rect_x_i        (rect_x),
    .rect_y_i        (rect_y),
    .rect_w_i        (rect_w),
    .rect_h_i        (rect_h),
    .fill_color_i    (fill_color),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .result_strobe_o (result_strobe),
    .is_command_o    (is_command),
    .bus_value_o     (bus_value),
    .two_bytes_o     (two_bytes),
    .repeat_count_o  (repeat_count),
    .last_item_o     (last_item)
  );

  rcw_checker u_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .busy_i          (busy),
    .rect_x_i        (rect_x),
    .rect_y_i        (rect_y),
    .rect_w_i        (rect_w),
    .rect_h_i        (rect_h),
    .fill_color_i    (fill_color),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .result_strobe_i (result_strobe),
    .is_command_i    (is_command),
    .bus_value_i     (bus_value),
    .two_bytes_i     (two_bytes),
    .repeat_count_i  (repeat_count),
    .last_item_i     (last_item),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // clock
  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog on cycles without any accepted request or result
  always @(posedge clk_i) begin
    if ((start && !busy) || result_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one rectangle request, start held high across back-to-back requests
  task automatic send_rect(input logic [FIELD_W-1:0] rx, input logic [FIELD_W-1:0] ry,
                           input logic [FIELD_W-1:0] rw, input logic [FIELD_W-1:0] rh,
                           input logic [FIELD_W-1:0] colour);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    rect_x     = rx;
    rect_y     = ry;
    rect_w     = rw;
    rect_h     = rh;
    fill_color = colour;
    start      = 1'b1;
    do @(posedge clk_i); while (busy);
  endtask

  // register write request
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int unsigned value);
    int gap;
    gap = idle_on ? $urandom_range(0, 14) : 0;
    repeat (gap) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid = 1'b0;
    if (idx == CFG_PANEL_WIDTH) cur_pw = int'(value[CFG_W-1:0]);
    if (idx == CFG_PANEL_HEIGHT) cur_ph = int'(value[CFG_W-1:0]);
  endtask

  // stop sending and let the block run dry
  task automatic drain();
    @(negedge clk_i);
    start = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // mostly well-formed rectangles near the panel, some edge sizes, some noise
  task automatic send_random_rect();
    int                 pw;
    int                 ph;
    int                 kind;
    logic [FIELD_W-1:0] rx;
    logic [FIELD_W-1:0] ry;
    logic [FIELD_W-1:0] rw;
    logic [FIELD_W-1:0] rh;
    pw = (cur_pw > int'(MAX_SIDE)) ? int'(MAX_SIDE) : cur_pw;
    ph = (cur_ph > int'(MAX_SIDE)) ? int'(MAX_SIDE) : cur_ph;
    if (pw < 1) pw = 64;
    if (ph < 1) ph = 64;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      rx = 16'(int'($urandom_range(0, pw + pw / 4)) - pw / 8);
      ry = 16'(int'($urandom_range(0, ph + ph / 4)) - ph / 8);
      rw = 16'($urandom_range(1, pw));
      rh = 16'($urandom_range(1, ph));
    end else if (kind < 85) begin
      rx = 16'(int'($urandom_range(0, 4)) - 2);
      ry = 16'(ph - int'($urandom_range(0, 3)));
      rw = 16'(int'($urandom_range(0, 6)) - 3);
      rh = 16'($urandom_range(0, 40000));
    end else begin
      rx = 16'($urandom());
      ry = 16'($urandom());
      rw = 16'($urandom());
      rh = 16'($urandom());
    end
    send_rect(rx, ry, rw, rh, 16'($urandom_range(0, 65535)));
  endtask

  // stimulus and verdict
  initial begin
    int pw_sel;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset configuration: inside, partial clips, empty and corner cases
    send_rect(16'd10, 16'd20, 16'd30, 16'd40, 16'h1234);
    send_rect(-16'sd5, 16'd0, 16'd10, 16'd10, 16'hFFFF);
    send_rect(16'd100, -16'sd7, 16'd5, 16'd9, 16'h0000);
    send_rect(16'd5, 16'd5, 16'd0, 16'd10, 16'hAAAA);
    send_rect(16'd5, 16'd5, 16'd10, -16'sd3, 16'h5555);
    send_rect(16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'hF800);
    send_rect(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h07E0);
    send_rect(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h001F);
    send_rect(16'd319, 16'd479, 16'd1, 16'd1, 16'hFFFF);
    send_rect(-16'sd1, -16'sd1, 16'd2, 16'd2, 16'h8001);
    send_rect(16'd0, 16'd0, 16'h8000, 16'h8000, 16'h7FFE);
    send_rect(16'd300, 16'd470, 16'd100, 16'd100, 16'hC3C3);
    idle_on = 1'b1;
    send_rect(16'h8000, 16'd0, 16'h7FFF, 16'd10, 16'h0F0F);
    send_rect(16'd320, 16'd0, 16'd1, 16'd1, 16'h3C3C);
    drain();

    // largest panel on the narrow bus
    write_reg(CFG_PANEL_WIDTH, MAX_SIDE);
    write_reg(CFG_PANEL_HEIGHT, MAX_SIDE);
    write_reg(CFG_WIDE_BUS, 0);
    write_reg(CFG_UNUSED, 2047);
    send_rect(16'd0, 16'd0, 16'h7FFF, 16'h7FFF, 16'hFFFF);
    send_rect(16'd1023, 16'd1023, 16'd4, 16'd4, 16'h0001);
    drain();

    // oversized panel settings are treated as the largest side
    write_reg(CFG_PANEL_WIDTH, 2047);
    write_reg(CFG_PANEL_HEIGHT, 1500);
    send_rect(-16'sd100, -16'sd100, 16'd3000, 16'd3000, 16'hABCD);
    send_rect(16'd1020, 16'd0, 16'd10, 16'd2, 16'h1111);
    drain();

    // zero panel sides clip everything away
    write_reg(CFG_PANEL_WIDTH, 0);
    write_reg(CFG_WIDE_BUS, 1);
    send_rect(16'd0, 16'd0, 16'd10, 16'd10, 16'h2222);
    drain();
    write_reg(CFG_PANEL_WIDTH, 1);
    write_reg(CFG_PANEL_HEIGHT, 0);
    send_rect(16'd0, 16'd0, 16'd10, 16'd10, 16'h4444);
    drain();

    // single-pixel panel
    write_reg(CFG_PANEL_HEIGHT, 1);
    send_rect(16'd0, 16'd0, 16'd5, 16'd5, 16'h6666);
    send_rect(-16'sd2, -16'sd2, 16'd3, 16'd3, 16'h9999);
    drain();

    // random phases, each with its own panel setting
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 0) begin
        write_reg(CFG_PANEL_WIDTH, MAX_SIDE);
        write_reg(CFG_PANEL_HEIGHT, 1);
        write_reg(CFG_WIDE_BUS, 1);
      end else if (phase == 1) begin
        write_reg(CFG_PANEL_WIDTH, 1);
        write_reg(CFG_PANEL_HEIGHT, MAX_SIDE);
        write_reg(CFG_WIDE_BUS, 0);
      end else begin
        pw_sel = $urandom_range(0, 19);
        if (pw_sel < 2) write_reg(CFG_PANEL_WIDTH, 2047);
        else if (pw_sel < 3) write_reg(CFG_PANEL_WIDTH, 0);
        else write_reg(CFG_PANEL_WIDTH, $urandom_range(1, MAX_SIDE));
        write_reg(CFG_PANEL_HEIGHT, $urandom_range(1, 2047));
        write_reg(CFG_WIDE_BUS, $urandom_range(0, 1));
      end
      for (int i = 0; i < 18; i++) begin
        if ($urandom_range(0, 7) == 0) idle_on = !idle_on;
        send_random_rect();
      end
      drain();
    end

    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* rect_clip_window_command_gen.f */
hdl/rcw_pkg.sv
hdl/rcw_clip.sv
hdl/rcw_queue.sv
hdl/rcw_seq.sv
hdl/rect_clip_window_command_gen.sv
tb/sv/rcw_checker.sv
tb/sv/tb_top.sv
